@@ src/text_string_candidate_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// text string candidate scanner assertion macros
// shared concurrent assertion forms, reset gated, reporting by $error
// ----------------------------------------------------------------------------
`ifndef TEXT_STRING_CANDIDATE_SCANNER_ASSERT_SVH
`define TEXT_STRING_CANDIDATE_SCANNER_ASSERT_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// types, constants and byte classification shared by the scanner modules
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    localparam int unsigned LEN_W          = 10;
    localparam int unsigned ADDR_W         = 3;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned BUFFER_BYTES_D = 256;
    localparam logic        IDX_WIDE_MODE  = 1'b0;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_LEAD = 2'd1,
        PEND_ZERO = 2'd2
    } t_pend;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_pend            pend;
        logic [7:0]       lead;
        logic             verdict;
    } t_scan_state;

    typedef struct packed {
        logic             fire;
        logic             found;
        logic [LEN_W-1:0] length;
    } t_step_res;

    function automatic logic [LEN_W-1:0] len_cap(input int unsigned bytes);
        int unsigned cap;
        cap = (2 * bytes < 1023) ? 2 * bytes : 1023;
        return LEN_W'(cap);
    endfunction

    function automatic logic can_lead(input logic [7:0] b);
        return (b >= 8'ha1 && b <= 8'ha9) || (b >= 8'hb0 && b <= 8'hf7);
    endfunction

    function automatic logic pair_valid(input logic [7:0] lead, input logic [7:0] trail);
        logic t_hi;
        t_hi = trail >= 8'ha1 && trail <= 8'hfe;
        return ((lead >= 8'ha1 && lead <= 8'ha9) && t_hi)
            || ((lead >= 8'ha8 && lead <= 8'ha9) && trail >= 8'h40 && trail <= 8'ha0)
            || ((lead >= 8'hb0 && lead <= 8'hf7) && t_hi);
    endfunction

endpackage

`default_nettype wire

@@ src/scs_if.sv @@
// ----------------------------------------------------------------------------
// scs_if
// valid/ready channels for scanner input bytes and verdicts
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface scs_out_if;
    logic       valid;
    logic       ready;
    logic       string_found;
    logic [9:0] display_length;

    modport source (output valid, output string_found, output display_length, input ready);
    modport sink   (input valid, input string_found, input display_length, output ready);
endinterface

`default_nettype wire

@@ src/scs_cfg.sv @@
// ----------------------------------------------------------------------------
// scs_cfg
// apb-style configuration register holding the wide mode flag
// ----------------------------------------------------------------------------
`default_nettype none

module scs_cfg
    import scs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic              i_reg_idx,
    input  wire logic [DATA_W-1:0] i_pwdata,
    output logic      [DATA_W-1:0] o_prdata,
    output logic                   o_wide_mode
);

    logic r_wide_mode;
    logic n_wide_mode;

    always_comb begin
        n_wide_mode = r_wide_mode;
        if (i_psel && i_penable && i_pwrite && i_reg_idx == IDX_WIDE_MODE) begin
            n_wide_mode = i_pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
        end else begin
            r_wide_mode <= n_wide_mode;
        end
    end

    assign o_prdata    = (i_reg_idx == IDX_WIDE_MODE) ? {{(DATA_W-1){1'b0}}, r_wide_mode}
                                                      : '0;
    assign o_wide_mode = r_wide_mode;

endmodule

`default_nettype wire

@@ src/scs_step.sv @@
// ----------------------------------------------------------------------------
// scs_step
// classifies one byte against the scan state and forms next state and verdict
// ----------------------------------------------------------------------------
`default_nettype none

module scs_step
    import scs_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_D
) (
    input  wire logic        i_wide_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_buffer_end,
    input  wire t_scan_state i_state,
    output t_scan_state      o_state,
    output t_step_res        o_res
);

    localparam logic [LEN_W-1:0] LenCap = len_cap(BUFFER_BYTES);

    typedef enum logic [1:0] {
        DEC_GO   = 2'd0,
        DEC_STOP = 2'd1,
        DEC_FAIL = 2'd2
    } t_decide;

    t_decide        decide;
    logic           examine;
    logic [1:0]     add_amt;
    logic [LEN_W:0] sum;
    t_scan_state    st;

    always_comb begin
        st      = i_state;
        decide  = DEC_GO;
        examine = 1'b1;
        add_amt = 2'd0;
        sum     = '0;
        o_res   = '0;

        if (!i_state.verdict) begin
            case (i_state.pend)
                PEND_LEAD: begin
                    examine = 1'b0;
                    st.pend = PEND_NONE;
                    st.lead = '0;
                    if (pair_valid(i_state.lead, i_data_byte)) begin
                        add_amt = 2'd2;
                    end else begin
                        decide = DEC_FAIL;
                    end
                end
                PEND_ZERO: begin
                    st.pend = PEND_NONE;
                    if (i_data_byte == 8'h00) begin
                        examine = 1'b0;
                        decide  = DEC_STOP;
                    end
                end
                default: ;
            endcase

            if (examine) begin
                if (i_wide_mode && i_buffer_end) begin
                    decide = DEC_STOP;
                end else if (i_data_byte == 8'h00) begin
                    if (i_wide_mode) begin
                        st.pend = PEND_ZERO;
                    end else begin
                        decide = DEC_STOP;
                    end
                end else if (i_data_byte == 8'h0d || i_data_byte == 8'h0a
                             || i_data_byte == 8'h09) begin
                    add_amt = 2'd2;
                end else if (i_data_byte >= 8'h20 && i_data_byte <= 8'h7f) begin
                    add_amt = 2'd1;
                end else if (can_lead(i_data_byte)) begin
                    if (i_buffer_end) begin
                        decide = DEC_FAIL;
                    end else begin
                        st.pend = PEND_LEAD;
                        st.lead = i_data_byte;
                    end
                end else begin
                    decide = DEC_FAIL;
                end
            end

            // saturating length update
            sum = {1'b0, i_state.len} + {{(LEN_W-1){1'b0}}, add_amt};
            if (sum > {1'b0, LenCap}) begin
                st.len = LenCap;
            end else begin
                st.len = sum[LEN_W-1:0];
            end

            if (decide == DEC_GO && i_buffer_end) begin
                decide = DEC_STOP;
            end

            if (decide != DEC_GO) begin
                o_res.fire   = 1'b1;
                o_res.found  = (decide == DEC_STOP) && (st.len != '0);
                o_res.length = st.len;
                st.verdict   = 1'b1;
            end
        end

        if (i_buffer_end) begin
            st = '0;
        end
        o_state = st;
    end

endmodule

`default_nettype wire

@@ src/text_string_candidate_scanner.sv @@
// ----------------------------------------------------------------------------
// text_string_candidate_scanner
// scans a buffer byte by byte for a leading printable or gb2312 string
// ----------------------------------------------------------------------------
//   channel   dir   handshake        payload
//   i_in      in    valid / ready    data_byte, buffer_end
//   o_out     out   valid / ready    string_found, display_length
//   apb       in    psel / penable   wide_mode at address 0
//
// one byte per cycle sustained unless a stalled verdict holds the input stage;
// bytes are classified from the input register into the result register
// synchronous active-low reset clears scan state, mode and both valid flags
// a stalled verdict holds the input stage only when that stage has a verdict
// of its own to deliver; bytes that give no verdict keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module text_string_candidate_scanner
    import scs_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_D
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    scs_in_if.sink                 i_in,
    scs_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    `include "text_string_candidate_scanner_assert.svh"

    localparam logic [LEN_W-1:0] LenCap = len_cap(BUFFER_BYTES);

    logic        wide_mode;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;
    t_scan_state r_state;
    t_scan_state n_state;
    t_step_res   step_res;
    logic        r_out_valid;
    logic        r_out_found;
    logic [9:0]  r_out_len;
    logic        s1_go;

    scs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_reg_idx   (paddr[2]),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_wide_mode (wide_mode)
    );

    scs_step #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_step (
        .i_wide_mode  (wide_mode),
        .i_data_byte  (r_in_byte),
        .i_buffer_end (r_in_end),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_res        (step_res)
    );

    assign pready = 1'b1;

    assign s1_go      = r_in_valid && (!step_res.fire || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s1_go;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (s1_go) begin
                r_state <= n_state;
            end
            if (s1_go && step_res.fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_end  <= i_in.buffer_end;
        end
        if (s1_go && step_res.fire) begin
            r_out_found <= step_res.found;
            r_out_len   <= step_res.length;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.string_found   = r_out_found;
    assign o_out.display_length = r_out_len;

    `SCS_ASSERT_NOW(a_found_nonempty, i_clk, i_rst_n,
        r_out_valid && r_out_found, r_out_len != '0, "verdict found with zero length")
    `SCS_ASSERT_NOW(a_len_capped, i_clk, i_rst_n,
        1'b1, r_state.len <= LenCap, "length above cap")
    `SCS_ASSERT_NOW(a_verdict_no_pend, i_clk, i_rst_n,
        r_state.verdict, r_state.pend == PEND_NONE, "pending byte after verdict")
    `SCS_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n,
        s1_go && r_in_end, r_state == '0, "scan state not cleared at buffer end")

endmodule

`default_nettype wire

@@ tb/text_string_candidate_scanner_tb.sv @@
// ----------------------------------------------------------------------------
// text_string_candidate_scanner_tb
// Feeds buffers of bytes through the scanner and checks every verdict against
// a cycle-free model of the scan kept in this file. Mode changes through the
// register port happen only with the pipeline drained. Directed buffers hit
// the byte class boundaries, the terminators, pair errors and a mid-buffer
// mode change. Random buffers follow: mostly well-formed strings, some broken
// ones, some noise and a few long runs that saturate the length.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none

module text_string_candidate_scanner_tb;
    import scs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEN_LIMIT =
        (2 * BUFFER_BYTES_D < 1023) ? 2 * BUFFER_BYTES_D : 1023;
    localparam logic [ADDR_W-1:0] WIDE_MODE_ADDR = ADDR_W'({IDX_WIDE_MODE, 2'b00});
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic MODE_ASCII = 1'b0;
    localparam logic MODE_WIDE  = 1'b1;

    typedef enum logic [1:0] {STEP_GO, STEP_STOP, STEP_FAIL} t_step;
    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HOLD} t_stall;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    typedef struct {
        logic             found;
        logic [LEN_W-1:0] length;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    scs_in_if  in_ch();
    scs_out_if out_ch();

    text_string_candidate_scanner #(.BUFFER_BYTES(BUFFER_BYTES_D)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    t_byte_req byte_requests[$];
    t_verdict  verdicts_due[$];
    int unsigned mismatch_count = 0;

    // scan state mirrored from the block
    logic             wide_sel = MODE_ASCII;
    logic [LEN_W-1:0] scan_len = '0;
    t_pend            scan_pend = PEND_NONE;
    logic [7:0]       scan_lead = '0;
    logic             scan_done = 1'b0;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic is_lead_byte(input logic [7:0] b);
        return (b >= 8'ha1 && b <= 8'ha9) || (b >= 8'hb0 && b <= 8'hf7);
    endfunction

    function automatic logic is_valid_pair(input logic [7:0] lead, input logic [7:0] trail);
        logic upper_trail;
        upper_trail = trail >= 8'ha1 && trail <= 8'hfe;
        if (lead >= 8'ha1 && lead <= 8'ha9 && upper_trail)
            return 1'b1;
        if (lead >= 8'ha8 && lead <= 8'ha9 && trail >= 8'h40 && trail <= 8'ha0)
            return 1'b1;
        return lead >= 8'hb0 && lead <= 8'hf7 && upper_trail;
    endfunction

    function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len,
                                              input int unsigned n);
        int unsigned sum;
        sum = len + n;
        if (sum > LEN_LIMIT)
            sum = LEN_LIMIT;
        return LEN_W'(sum);
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic last);
        t_step    step;
        logic     examine;
        t_verdict verdict;
        step = STEP_GO;
        examine = 1'b1;
        if (!scan_done) begin
            if (scan_pend == PEND_LEAD) begin
                examine = 1'b0;
                scan_pend = PEND_NONE;
                if (is_valid_pair(scan_lead, b))
                    scan_len = grow(scan_len, 2);
                else
                    step = STEP_FAIL;
                scan_lead = '0;
            end else if (scan_pend == PEND_ZERO) begin
                scan_pend = PEND_NONE;
                if (b == CH_NUL) begin
                    examine = 1'b0;
                    step = STEP_STOP;
                end
            end
            if (examine && step == STEP_GO) begin
                if (wide_sel && last) begin
                    step = STEP_STOP;
                end else if (b == CH_NUL) begin
                    if (wide_sel)
                        scan_pend = PEND_ZERO;
                    else
                        step = STEP_STOP;
                end else if (b == CH_CR || b == CH_LF || b == CH_TAB) begin
                    scan_len = grow(scan_len, 2);
                end else if (b >= 8'h20 && b <= 8'h7f) begin
                    scan_len = grow(scan_len, 1);
                end else if (is_lead_byte(b)) begin
                    if (last) begin
                        step = STEP_FAIL;
                    end else begin
                        scan_pend = PEND_LEAD;
                        scan_lead = b;
                    end
                end else begin
                    step = STEP_FAIL;
                end
            end
            if (step == STEP_GO && last)
                step = STEP_STOP;
            if (step != STEP_GO) begin
                verdict.found = step == STEP_STOP && scan_len != 0;
                verdict.length = scan_len;
                verdicts_due.push_back(verdict);
                scan_done = 1'b1;
            end
        end
        if (last) begin
            scan_len = '0;
            scan_pend = PEND_NONE;
            scan_lead = '0;
            scan_done = 1'b0;
        end
    endtask

    // request driver, bursts with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    t_byte_req   next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                scan_byte(in_ch.data_byte, in_ch.buffer_end);
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (byte_requests.size() != 0) begin
                    next_req = byte_requests.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= next_req.data;
                    in_ch.buffer_end <= next_req.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    t_stall      stall_style = STALL_NONE;
    int unsigned stall_cycle = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 300 == 0)
            stall_style = t_stall'($urandom_range(0, 2));
        case (stall_style)
            STALL_NONE: begin
                out_ch.ready <= 1'b1;
            end
            STALL_COIN: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        hold_left = $urandom_range(1, 15);
                end
            end
        endcase
    end

    // verdict monitor
    t_verdict want;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict with none pending: found %0b length %0d",
                                          out_ch.string_found, out_ch.display_length));
            end else begin
                want = verdicts_due.pop_front();
                if (out_ch.string_found !== want.found)
                    report_mismatch($sformatf("string_found %0b, predicted %0b",
                                              out_ch.string_found, want.found));
                if (out_ch.display_length !== want.length)
                    report_mismatch($sformatf("display_length %0d, predicted %0d",
                                              out_ch.display_length, want.length));
            end
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == WIDE_MODE_ADDR)
            wide_sel = value[0];
    endtask

    task automatic push_bytes(input logic [7:0] bytes[$], input logic closes);
        t_byte_req req;
        for (int i = 0; i < bytes.size(); i++) begin
            req.data = bytes[i];
            req.last = closes && (i == bytes.size() - 1);
            byte_requests.push_back(req);
        end
    endtask

    task automatic wait_idle();
        while (byte_requests.size() != 0 || in_ch.valid || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_lead();
        case ($urandom_range(0, 2))
            0: return 8'($urandom_range(8'ha1, 8'ha9));
            1: return 8'($urandom_range(8'ha8, 8'ha9));
            default: return 8'($urandom_range(8'hb0, 8'hf7));
        endcase
    endfunction

    function automatic logic [7:0] random_trail(input logic [7:0] lead);
        if (lead >= 8'ha8 && lead <= 8'ha9 && $urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h40, 8'ha0));
        return 8'($urandom_range(8'ha1, 8'hfe));
    endfunction

    function automatic logic [7:0] random_control();
        case ($urandom_range(0, 2))
            0: return CH_CR;
            1: return CH_LF;
            default: return CH_TAB;
        endcase
    endfunction

    task automatic queue_random_buffer(input logic wide, output int pushed);
        logic [7:0] body[$];
        logic [7:0] lead;
        logic [7:0] b;
        int shape;
        int span;
        int pick;
        logic long_run;
        logic lead_last;
        shape = $urandom_range(0, 99);
        long_run = $urandom_range(0, 59) == 0;
        lead_last = 1'b0;
        span = long_run ? $urandom_range(258, 300) : $urandom_range(0, 14);
        for (int i = 0; i < span; i++) begin
            pick = long_run ? 5 : $urandom_range(0, 9);
            if (pick < 5 || pick == 9) begin
                body.push_back(8'($urandom_range(8'h20, 8'h7f)));
            end else if (pick == 5) begin
                body.push_back(random_control());
            end else if (pick < 8) begin
                lead = random_lead();
                body.push_back(lead);
                body.push_back(random_trail(lead));
            end else if (wide) begin
                body.push_back(CH_NUL);
            end else begin
                body.push_back(8'($urandom_range(8'h20, 8'h7f)));
            end
        end
        if (shape < 12) begin
            // a byte of no valid class somewhere in the string
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_NUL || b == CH_CR || b == CH_LF || b == CH_TAB
                   || (b >= 8'h20 && b <= 8'h7f) || is_lead_byte(b));
            body.insert($urandom_range(0, body.size()), b);
        end else if (shape < 20) begin
            lead = random_lead();
            do
                b = 8'($urandom_range(0, 255));
            while (is_valid_pair(lead, b));
            body.push_back(lead);
            body.push_back(b);
        end else if (shape < 26) begin
            body.push_back(random_lead());
            lead_last = 1'b1;
        end else if (shape < 34) begin
            body.delete();
            span = $urandom_range(1, 12);
            for (int i = 0; i < span; i++)
                body.push_back(8'($urandom_range(0, 255)));
            lead_last = 1'b1;
        end
        if (!lead_last) begin
            if (wide && $urandom_range(0, 9) < 6) begin
                body.push_back(CH_NUL);
                body.push_back(CH_NUL);
            end else if (!wide && $urandom_range(0, 9) < 7) begin
                body.push_back(CH_NUL);
            end
            span = $urandom_range(0, 3);
            for (int i = 0; i < span; i++)
                body.push_back(8'($urandom_range(0, 255)));
        end
        if (body.size() == 0)
            body.push_back(8'($urandom_range(0, 255)));
        push_bytes(body, 1'b1);
        pushed = body.size();
    endtask

    int phase_items;
    int pushed;

    initial begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.buffer_end = 1'b0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ascii rules: class edges, pairs, empty, bad byte, bad trail, lead at end
        write_reg(WIDE_MODE_ADDR, DATA_W'(MODE_ASCII));
        push_bytes('{8'h20, 8'h7f, CH_CR, CH_LF, CH_TAB, 8'ha1, 8'ha1, 8'hf7, 8'hfe,
                     8'ha9, 8'h40, CH_NUL}, 1'b1);
        push_bytes('{CH_NUL}, 1'b1);
        push_bytes('{8'h41, 8'h80}, 1'b1);
        push_bytes('{8'hb0, 8'h41}, 1'b1);
        push_bytes('{8'h41, 8'hb0}, 1'b1);
        wait_idle();

        // wide rules: single zeros skipped, double zero, final byte unexamined
        write_reg(WIDE_MODE_ADDR, DATA_W'(MODE_WIDE));
        push_bytes('{8'h41, CH_NUL, 8'h42, CH_NUL, CH_NUL}, 1'b1);
        push_bytes('{8'h41, 8'hff}, 1'b1);
        push_bytes('{8'h41}, 1'b0);
        wait_idle();
        // mode change in the middle of a buffer
        write_reg(WIDE_MODE_ADDR, DATA_W'(MODE_ASCII));
        push_bytes('{CH_NUL}, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            write_reg(WIDE_MODE_ADDR, (p < 2) ? DATA_W'(p) : DATA_W'($urandom_range(0, 1)));
            phase_items = 0;
            while (phase_items < 206) begin
                queue_random_buffer(wide_sel, pushed);
                phase_items += pushed;
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (verdicts_due.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
